// ----- rtl/core/sfa_pkg.sv -----
// Shared constants, codes and header type for the second-fit block allocator.
package sfa_pkg;

  localparam int ARENA_BYTES  = 4096;
  localparam int HEADER_BYTES = 16;
  localparam int OFF_W  = $clog2(ARENA_BYTES);
  localparam int SIZE_W = OFF_W + 1;
  localparam int LEN_W  = OFF_W;

  localparam logic [SIZE_W-1:0] ARENA_MAX = SIZE_W'(ARENA_BYTES);
  localparam logic [SIZE_W-1:0] ARENA_MIN = SIZE_W'(HEADER_BYTES + 1);
  localparam logic [SIZE_W-1:0] HDR_SZ    = SIZE_W'(HEADER_BYTES);

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_LEAK  = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FAILED  = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  // One block header: in-use bit and payload length.
  typedef struct packed {
    logic             used;
    logic [LEN_W-1:0] len;
  } hdr_t;

endpackage

// ----- rtl/core/second_fit_block_allocator_unit.sv -----
// Top level: header memory and the walk sequencer for alloc, free and leak check.
//
//  channel | ports                                          | handshake
//  --------+------------------------------------------------+------------------------
//  input   | in_func, in_request_size, in_address           | start high, busy low
//  result  | out_status, out_payload_offset, out_leak_found | out_valid one-cycle strobe
//  config  | cfg_data                                       | cfg_valid and cfg_ready
//
// The headers live in one synchronous memory; the walk reads one header per cycle,
// so an item's run time grows with the number of blocks it visits before its
// strobe. Zero-size alloc and code 3 are answered from idle without a walk.
// After reset or an arena size write, the init state writes the single free header
// at 0; busy stays high meanwhile. Results cannot be held off by the receiver.
module second_fit_block_allocator_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_func,
  input  logic [sfa_pkg::LEN_W-1:0] in_request_size,
  input  logic [sfa_pkg::OFF_W-1:0] in_address,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [sfa_pkg::OFF_W-1:0] out_payload_offset,
  output logic                      out_leak_found,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [sfa_pkg::SIZE_W-1:0] cfg_data
);
  import sfa_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_AEV  = 3'd2;
  localparam logic [2:0] S_ASPL = 3'd3;
  localparam logic [2:0] S_FEV  = 3'd4;
  localparam logic [2:0] S_FNX  = 3'd5;
  localparam logic [2:0] S_FWR  = 3'd6;
  localparam logic [2:0] S_LEV  = 3'd7;

  logic [SIZE_W-1:0] arena_size;
  logic              cfg_wr;

  // Header memory, one read and one write port.
  hdr_t              mem [ARENA_BYTES];
  hdr_t              rd_q;
  logic [OFF_W-1:0]  rd_addr;
  logic              wr_en;
  logic [OFF_W-1:0]  wr_addr;
  hdr_t              wr_data;

  logic [2:0]        state_r, state_nxt;
  logic [LEN_W-1:0]  req_r, req_nxt;
  logic [OFF_W-1:0]  addr_r, addr_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [1:0]        found_r, found_nxt;
  logic [OFF_W-1:0]  pick_r, pick_nxt;
  logic [LEN_W-1:0]  pick_len_r, pick_len_nxt;
  logic [OFF_W-1:0]  prev_r, prev_nxt;
  logic              prev_used_r, prev_used_nxt;
  logic [LEN_W-1:0]  prev_len_r, prev_len_nxt;
  logic              have_prev_r, have_prev_nxt;
  logic [LEN_W-1:0]  cur_len_r, cur_len_nxt;
  logic              nxt_free_r, nxt_free_nxt;
  logic [LEN_W-1:0]  nxt_len_r, nxt_len_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [OFF_W-1:0]  out_payload_offset_r, out_payload_offset_nxt;
  logic              out_leak_found_r, out_leak_found_nxt;

  logic [SIZE_W-1:0] next_off;
  logic [SIZE_W-1:0] pay_off;
  logic              fit;
  logic [1:0]        cnt;
  logic [OFF_W-1:0]  p_sel;
  logic [LEN_W-1:0]  plen_sel;
  logic [SIZE_W-1:0] req_hdr;
  logic              merge_prev;
  logic [SIZE_W-1:0] len1;
  logic [SIZE_W-1:0] len2;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !start;
  assign cfg_wr    = cfg_valid && cfg_ready;

  sfa_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (cfg_wr),
    .wr_data    (cfg_data),
    .arena_size (arena_size)
  );

  // Memory access; a read that meets a write to the same entry is never used.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Quantities derived from the header just read.
  always_comb begin
    next_off   = SIZE_W'(off_r) + HDR_SZ + SIZE_W'(rd_q.len);
    pay_off    = SIZE_W'(off_r) + HDR_SZ;
    fit        = !rd_q.used && (rd_q.len >= req_r);
    cnt        = found_r + {1'b0, fit};
    p_sel      = fit ? off_r : pick_r;
    plen_sel   = fit ? rd_q.len : pick_len_r;
    req_hdr    = SIZE_W'(req_r) + HDR_SZ;
    merge_prev = have_prev_r && !prev_used_r;
    len1       = merge_prev ? (SIZE_W'(prev_len_r) + HDR_SZ + SIZE_W'(cur_len_r))
                            : SIZE_W'(cur_len_r);
    len2       = nxt_free_r ? (len1 + HDR_SZ + SIZE_W'(nxt_len_r)) : len1;
  end

  // Walk sequencer.
  always_comb begin
    state_nxt              = state_r;
    req_nxt                = req_r;
    addr_nxt               = addr_r;
    off_nxt                = off_r;
    found_nxt              = found_r;
    pick_nxt               = pick_r;
    pick_len_nxt           = pick_len_r;
    prev_nxt               = prev_r;
    prev_used_nxt          = prev_used_r;
    prev_len_nxt           = prev_len_r;
    have_prev_nxt          = have_prev_r;
    cur_len_nxt            = cur_len_r;
    nxt_free_nxt           = nxt_free_r;
    nxt_len_nxt            = nxt_len_r;
    out_valid_nxt          = 1'b0;
    out_status_nxt         = out_status_r;
    out_payload_offset_nxt = out_payload_offset_r;
    out_leak_found_nxt     = out_leak_found_r;
    rd_addr                = '0;
    wr_en                  = 1'b0;
    wr_addr                = '0;
    wr_data                = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt                = in_request_size;
          addr_nxt               = in_address;
          off_nxt                = '0;
          found_nxt              = '0;
          have_prev_nxt          = 1'b0;
          out_status_nxt         = ST_DONE;
          out_payload_offset_nxt = '0;
          out_leak_found_nxt     = 1'b0;
          unique case (in_func)
            FUNC_ALLOC: begin
              if (in_request_size == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_FAILED;
              end else begin
                state_nxt = S_AEV;
              end
            end
            FUNC_FREE: state_nxt = S_FEV;
            FUNC_LEAK: state_nxt = S_LEV;
            default:   out_valid_nxt = 1'b1;
          endcase
        end else if (cfg_valid) begin
          state_nxt = S_INIT;
        end
      end

      S_INIT: begin
        // One free block spanning the arena.
        wr_en        = 1'b1;
        wr_addr      = '0;
        wr_data.used = 1'b0;
        wr_data.len  = LEN_W'(arena_size - HDR_SZ);
        state_nxt    = S_IDLE;
      end

      S_AEV: begin
        found_nxt = cnt;
        if (fit) begin
          pick_nxt     = off_r;
          pick_len_nxt = rd_q.len;
        end
        if (cnt == 2'd2 || next_off >= arena_size) begin
          if (cnt == 2'd0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_FAILED;
            state_nxt      = S_IDLE;
          end else begin
            // Claim the chosen block; its length shrinks when it is split.
            wr_en        = 1'b1;
            wr_addr      = p_sel;
            wr_data.used = 1'b1;
            wr_data.len  = (SIZE_W'(plen_sel) > req_hdr) ? req_r : plen_sel;
            state_nxt    = S_ASPL;
          end
        end else begin
          rd_addr = next_off[OFF_W-1:0];
          off_nxt = next_off[OFF_W-1:0];
        end
      end

      S_ASPL: begin
        // Write the free remainder header when the leftover exceeds a header.
        if (SIZE_W'(pick_len_r) > req_hdr) begin
          wr_en        = 1'b1;
          wr_addr      = OFF_W'(SIZE_W'(pick_r) + req_hdr);
          wr_data.used = 1'b0;
          wr_data.len  = LEN_W'(SIZE_W'(pick_len_r) - req_hdr);
        end
        out_valid_nxt          = 1'b1;
        out_status_nxt         = ST_DONE;
        out_payload_offset_nxt = OFF_W'(SIZE_W'(pick_r) + HDR_SZ);
        state_nxt              = S_IDLE;
      end

      S_FEV: begin
        if (SIZE_W'(addr_r) > pay_off) begin
          prev_nxt      = off_r;
          prev_used_nxt = rd_q.used;
          prev_len_nxt  = rd_q.len;
          have_prev_nxt = 1'b1;
          if (next_off < arena_size) begin
            rd_addr = next_off[OFF_W-1:0];
            off_nxt = next_off[OFF_W-1:0];
          end else begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_IGNORED;
            state_nxt      = S_IDLE;
          end
        end else if (SIZE_W'(addr_r) == pay_off && rd_q.used) begin
          cur_len_nxt = rd_q.len;
          if (next_off < arena_size) begin
            rd_addr   = next_off[OFF_W-1:0];
            state_nxt = S_FNX;
          end else begin
            nxt_free_nxt = 1'b0;
            state_nxt    = S_FWR;
          end
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_IGNORED;
          state_nxt      = S_IDLE;
        end
      end

      S_FNX: begin
        nxt_free_nxt = !rd_q.used;
        nxt_len_nxt  = rd_q.len;
        state_nxt    = S_FWR;
      end

      S_FWR: begin
        // Merge with free neighbors and write the surviving header.
        wr_en          = 1'b1;
        wr_addr        = merge_prev ? prev_r : off_r;
        wr_data.used   = 1'b0;
        wr_data.len    = LEN_W'(len2);
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_DONE;
        state_nxt      = S_IDLE;
      end

      S_LEV: begin
        if (rd_q.used) begin
          out_valid_nxt      = 1'b1;
          out_leak_found_nxt = 1'b1;
          state_nxt          = S_IDLE;
        end else if (next_off < arena_size) begin
          rd_addr = next_off[OFF_W-1:0];
          off_nxt = next_off[OFF_W-1:0];
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Walk and result payload registers.
  always_ff @(posedge clk) begin
    req_r                <= req_nxt;
    addr_r               <= addr_nxt;
    off_r                <= off_nxt;
    found_r              <= found_nxt;
    pick_r               <= pick_nxt;
    pick_len_r           <= pick_len_nxt;
    prev_r               <= prev_nxt;
    prev_used_r          <= prev_used_nxt;
    prev_len_r           <= prev_len_nxt;
    have_prev_r          <= have_prev_nxt;
    cur_len_r            <= cur_len_nxt;
    nxt_free_r           <= nxt_free_nxt;
    nxt_len_r            <= nxt_len_nxt;
    out_status_r         <= out_status_nxt;
    out_payload_offset_r <= out_payload_offset_nxt;
    out_leak_found_r     <= out_leak_found_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_payload_offset = out_payload_offset_r;
  assign out_leak_found     = out_leak_found_r;

endmodule

// ----- rtl/core/sfa_cfg.sv -----
// Arena size register with range clamp on write.
module sfa_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr,
  input  logic [sfa_pkg::SIZE_W-1:0] wr_data,
  output logic [sfa_pkg::SIZE_W-1:0] arena_size
);
  import sfa_pkg::*;

  logic [SIZE_W-1:0] arena_size_r;
  logic [SIZE_W-1:0] arena_size_nxt;

  // Clamp the written word to one header plus one byte up to the full arena.
  always_comb begin
    arena_size_nxt = arena_size_r;
    if (wr) begin
      if (wr_data > ARENA_MAX) begin
        arena_size_nxt = ARENA_MAX;
      end else if (wr_data < ARENA_MIN) begin
        arena_size_nxt = ARENA_MIN;
      end else begin
        arena_size_nxt = wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arena_size_r <= ARENA_MAX;
    end else begin
      arena_size_r <= arena_size_nxt;
    end
  end

  assign arena_size = arena_size_r;

endmodule
